[rtl/core/prbs_longest_clean_run_checker_unit_macros.svh]
// assertion helpers for the longest clean run checker
`ifndef PRBS_LONGEST_CLEAN_RUN_CHECKER_UNIT_MACROS_SVH
`define PRBS_LONGEST_CLEAN_RUN_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define PLCRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication, disabled during reset
`define PLCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define PLCRC_ASSERT_NOW(lbl, ante, cons)
`define PLCRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/plcrc_pkg.sv]
package plcrc_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int OUT_W = 32;
  localparam int PRIME_COUNT = 32;
  localparam logic [31:0] TAP_MASK = 32'h8040_1020;
  localparam logic [31:0] REQ_RUN_RESET = 32'd16777280;
  localparam logic [13:0] VALUE_OFFSET = 14'd8192;

  // per-request status flags from the run tracker
  typedef struct packed {
    logic mismatch;
    logic primed;
    logic enough;
  } flags_t;

endpackage

[rtl/core/plcrc_run_tracker.sv]
module plcrc_run_tracker #(
  parameter int POSITION_BITS = plcrc_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        seq_bit,
  input  logic [31:0]                 required_run,
  output plcrc_pkg::flags_t           flags,
  output logic [plcrc_pkg::OUT_W-1:0] best_length,
  output logic [plcrc_pkg::OUT_W-1:0] best_offset
);
  import plcrc_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int CW = (PW > 32) ? PW : 32;

  logic [31:0]   seq_r, seq_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] lmp_r, lmp_nxt;
  logic [PW-1:0] best_start_r, best_start_nxt;
  logic [PW-1:0] longest_r, longest_nxt;

  logic          compare_en;
  logic          pred;
  logic          mis;
  logic [PW-1:0] run_len;
  logic [PW:0]   pos_inc;
  logic          open_ok;
  logic [PW-1:0] open_len;
  logic [PW-1:0] show_len;
  logic [PW-1:0] show_off;

  always_comb begin
    compare_en = (pos_r >= PW'(PRIME_COUNT));
    pred       = ^(seq_r & TAP_MASK);
    mis        = compare_en && (pred != seq_bit);
    run_len    = pos_r - lmp_r;

    longest_nxt    = longest_r;
    best_start_nxt = best_start_r;
    lmp_nxt        = lmp_r;
    if (mis) begin
      if (run_len > longest_r) begin
        longest_nxt    = run_len;
        best_start_nxt = lmp_r;
      end
      lmp_nxt = pos_r;
    end

    // open run ending with this request
    pos_inc  = {1'b0, pos_r} + {{PW{1'b0}}, 1'b1};
    open_ok  = pos_inc > {1'b0, lmp_nxt};
    open_len = PW'(pos_inc - {1'b0, lmp_nxt});

    show_len = longest_nxt;
    show_off = best_start_nxt;
    if (open_ok && (open_len > longest_nxt)) begin
      show_len = open_len;
      show_off = lmp_nxt;
    end

    seq_nxt = {seq_r[30:0], seq_bit};
    pos_nxt = (&pos_r) ? pos_r : PW'(pos_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= '0;
      pos_r        <= '0;
      lmp_r        <= PW'(PRIME_COUNT - 1);
      best_start_r <= PW'(PRIME_COUNT - 1);
      longest_r    <= '0;
    end else if (fire) begin
      seq_r        <= seq_nxt;
      pos_r        <= pos_nxt;
      lmp_r        <= lmp_nxt;
      best_start_r <= best_start_nxt;
      longest_r    <= longest_nxt;
    end
  end

  assign flags.mismatch = mis;
  assign flags.primed   = (pos_r >= PW'(PRIME_COUNT - 1));
  assign flags.enough   = (CW'(show_len) >= CW'(required_run));
  assign best_length    = OUT_W'(show_len);
  assign best_offset    = OUT_W'(show_off);

endmodule

[rtl/core/prbs_longest_clean_run_checker_unit.sv]
// a request passes from the input register through the run tracker into the result register
//   (input reg, result reg)
// throughput: one request per cycle unless out_stall holds a result; the run tracker state updates on fire
// one request is held in the input register while a finished result waits on out_stall
// reset: synchronous active-low rst_n clears both valid flags and resets the tracker state,
//   required_run returns to 16777280
`include "prbs_longest_clean_run_checker_unit_macros.svh"

module prbs_longest_clean_run_checker_unit #(
  parameter int POSITION_BITS = plcrc_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_sample_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_mismatch,
  output logic        out_primed,
  output logic [31:0] out_best_length,
  output logic [31:0] out_best_offset,
  output logic        out_enough,
  output logic [13:0] out_sample_value,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import plcrc_pkg::*;

  // word index of each config register (paddr[2])
  localparam logic REG_REQUIRED_RUN = 1'b0;

  // config register
  logic [31:0] required_run_r;
  logic        cfg_wr;

  // input register stage
  logic        in_v_r, in_v_nxt;
  logic [7:0]  in_byte_r;

  // result register stage
  logic        out_v_r, out_v_nxt;
  logic        mismatch_r, primed_r, enough_r;
  logic [31:0] length_r, best_off_r;
  logic [13:0] sample_val_r;

  logic        advance;
  logic        fire;
  logic        in_take;
  logic        out_take;

  flags_t      trk_flags;
  logic [31:0] trk_len;
  logic [31:0] trk_off;
  logic [13:0] sample_val;

  // ---------------------------------------------------------------------------
  // config port: always ready, one word register at offset zero
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      required_run_r <= REQ_RUN_RESET;
    end else if (cfg_wr && (paddr[2] == REG_REQUIRED_RUN)) begin
      required_run_r <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REQUIRED_RUN: prdata = required_run_r;
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: result register empties or is taken -> pipeline moves
  // ---------------------------------------------------------------------------
  assign advance  = !out_v_r || !out_stall;
  assign fire     = in_v_r && advance;
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_v_r && !out_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_sample_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // run tracking: sequence register, position counter, best run bookkeeping
  // ---------------------------------------------------------------------------
  plcrc_run_tracker #(
    .POSITION_BITS(POSITION_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .seq_bit      (in_byte_r[7]),
    .required_run (required_run_r),
    .flags        (trk_flags),
    .best_length  (trk_len),
    .best_offset  (trk_off)
  );

  // low seven bits as signed sample, shifted up by the mid-scale offset
  assign sample_val = VALUE_OFFSET + {{7{in_byte_r[6]}}, in_byte_r[6:0]};

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      mismatch_r   <= trk_flags.mismatch;
      primed_r     <= trk_flags.primed;
      enough_r     <= trk_flags.enough;
      length_r     <= trk_len;
      best_off_r   <= trk_off;
      sample_val_r <= sample_val;
    end
  end

  assign out_valid        = out_v_r;
  assign out_mismatch     = mismatch_r;
  assign out_primed       = primed_r;
  assign out_best_length  = length_r;
  assign out_best_offset  = best_off_r;
  assign out_enough       = enough_r;
  assign out_sample_value = sample_val_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a mismatch can only be flagged once the sequence register is filled
  `PLCRC_ASSERT_NOW(a_mis_needs_primed, out_v_r && mismatch_r, primed_r)
  // before priming no run is counted yet
  `PLCRC_ASSERT_NOW(a_unprimed_no_run, out_v_r && !primed_r, (length_r == '0) && (best_off_r == 32'd31))
  // back-pressure only while the input register holds a request
  `PLCRC_ASSERT_NOW(a_stall_needs_item, in_stall, in_v_r)
  // a request moved forward always shows up as a valid result
  `PLCRC_ASSERT_NEXT(a_fire_gives_result, fire, out_v_r)

endmodule

[tb/sv/prbs_longest_clean_run_checker_unit_scoreboard.sv]
`timescale 1ns / 100ps

module prbs_longest_clean_run_checker_unit_scoreboard #(
  parameter int         POS_W    = 32,
  parameter logic [2:0] CFG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_sample_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_mismatch,
  input  logic        out_primed,
  input  logic [31:0] out_best_length,
  input  logic [31:0] out_best_offset,
  input  logic        out_enough,
  input  logic [13:0] out_sample_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          pending,
  output int          fail_count
);
  import plcrc_pkg::*;

  typedef struct packed {
    logic        mismatch;
    logic        primed;
    logic [31:0] best_length;
    logic [31:0] best_offset;
    logic        enough;
    logic [13:0] sample_value;
  } run_report_t;

  run_report_t      awaited_reports[$];
  logic [31:0]      required_run;
  logic [31:0]      seq_reg;
  logic [POS_W-1:0] next_idx;
  logic [POS_W-1:0] last_err_idx;
  logic [POS_W-1:0] best_from;
  logic [POS_W-1:0] longest;
  int               results_seen;

  initial begin
    pending = 0;
    fail_count = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got %0h, want %0h (result %0d)", $time, what, got, want,
             results_seen);
    fail_count++;
  endtask

  // one shift-and-compare step of the run tracker
  task automatic advance_run_tracker(input logic [7:0] smp, output run_report_t rep);
    logic [63:0] idx;
    logic [63:0] closed_len;
    logic [63:0] open_len;
    logic [63:0] show_len;
    logic [63:0] show_from;
    logic        err;
    idx = 64'(next_idx);
    err = 1'b0;
    if (idx >= 64'(PRIME_COUNT) && (^(seq_reg & TAP_MASK)) != smp[7]) begin
      err = 1'b1;
      closed_len = idx - 64'(last_err_idx);
      if (closed_len > 64'(longest)) begin
        longest = closed_len[POS_W-1:0];
        best_from = last_err_idx;
      end
      last_err_idx = next_idx;
    end
    seq_reg = {seq_reg[30:0], smp[7]};
    show_len = 64'(longest);
    show_from = 64'(best_from);
    // the open run counts once it has started
    if (idx + 64'd1 > 64'(last_err_idx)) begin
      open_len = idx + 64'd1 - 64'(last_err_idx);
      if (open_len > show_len) begin
        show_len = open_len;
        show_from = 64'(last_err_idx);
      end
    end
    // position counter saturates
    if (next_idx != '1)
      next_idx = next_idx + 1'b1;
    rep.mismatch = err;
    rep.primed = (idx >= 64'(PRIME_COUNT - 1));
    rep.best_length = show_len[31:0];
    rep.best_offset = show_from[31:0];
    rep.enough = (show_len >= 64'(required_run));
    rep.sample_value = VALUE_OFFSET + {{7{smp[6]}}, smp[6:0]};
  endtask

  always @(posedge clk) begin
    run_report_t want;
    run_report_t got;
    if (!rst_n) begin
      awaited_reports.delete();
      required_run = REQ_RUN_RESET;
      seq_reg = '0;
      next_idx = '0;
      last_err_idx = POS_W'(PRIME_COUNT - 1);
      best_from = POS_W'(PRIME_COUNT - 1);
      longest = '0;
    end else begin
      if (psel && penable && pready && paddr == CFG_ADDR) begin
        if (pwrite)
          required_run = pwdata;
        else if (prdata !== required_run)
          report_mismatch("required_run readback", 64'(prdata), 64'(required_run));
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_reports.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_best_length), 64'd0);
        end else begin
          want = awaited_reports.pop_front();
          got = '{out_mismatch, out_primed, out_best_length, out_best_offset, out_enough,
                  out_sample_value};
          if (got.mismatch !== want.mismatch)
            report_mismatch("mismatch", 64'(got.mismatch), 64'(want.mismatch));
          if (got.primed !== want.primed)
            report_mismatch("primed", 64'(got.primed), 64'(want.primed));
          if (got.best_length !== want.best_length)
            report_mismatch("best_length", 64'(got.best_length), 64'(want.best_length));
          if (got.best_offset !== want.best_offset)
            report_mismatch("best_offset", 64'(got.best_offset), 64'(want.best_offset));
          if (got.enough !== want.enough)
            report_mismatch("enough", 64'(got.enough), 64'(want.enough));
          if (got.sample_value !== want.sample_value)
            report_mismatch("sample_value", 64'(got.sample_value), 64'(want.sample_value));
        end
      end
      if (in_valid && !in_stall) begin
        advance_run_tracker(in_sample_byte, want);
        awaited_reports.push_back(want);
      end
    end
    pending = awaited_reports.size();
  end

endmodule

[tb/sv/prbs_longest_clean_run_checker_unit_tb.sv]
`timescale 1ns / 100ps

module prbs_longest_clean_run_checker_unit_tb;
  import plcrc_pkg::*;

  // position counter width
  localparam int         POS_W             = 16;
  localparam logic [2:0] ADDR_REQUIRED_RUN = 3'd0;
  localparam int         RANDOM_PER_PHASE  = 535;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_sample_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_mismatch;
  logic        out_primed;
  logic [31:0] out_best_length;
  logic [31:0] out_best_offset;
  logic        out_enough;
  logic [13:0] out_sample_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int fail_count;

  // idle percentages of the sender and the receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // shadow of the bits sent so far, used to shape well-formed sequences
  logic [31:0] sent_bits = 32'h0;
  int          sent_count = 0;

  // byte extremes used while the shift register primes
  logic [7:0] corner_bytes [8] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h40, 8'h3F, 8'hC0, 8'h01};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prbs_longest_clean_run_checker_unit #(
    .POSITION_BITS(POS_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_byte   (in_sample_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mismatch     (out_mismatch),
    .out_primed       (out_primed),
    .out_best_length  (out_best_length),
    .out_best_offset  (out_best_offset),
    .out_enough       (out_enough),
    .out_sample_value (out_sample_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  prbs_longest_clean_run_checker_unit_scoreboard #(
    .POS_W    (POS_W),
    .CFG_ADDR (ADDR_REQUIRED_RUN)
  ) run_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_byte   (in_sample_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mismatch     (out_mismatch),
    .out_primed       (out_primed),
    .out_best_length  (out_best_length),
    .out_best_offset  (out_best_offset),
    .out_enough       (out_enough),
    .out_sample_value (out_sample_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one request on the input channel; returns at the edge that accepts it
  task automatic send_sample(input logic [7:0] smp);
    // random gaps before the request, so idle cycles land on every phase
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_byte <= smp;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent_bits = {sent_bits[30:0], smp[7]};
    sent_count++;
  endtask

  // next bit of the sequence, inverted when flip is set; random low bits
  task automatic send_prbs(input logic flip);
    logic seq_bit;
    if (sent_count < PRIME_COUNT)
      seq_bit = 1'($urandom);
    else
      seq_bit = (^(sent_bits & TAP_MASK)) ^ flip;
    send_sample({seq_bit, 7'($urandom)});
  endtask

  // one apb transfer: setup cycle, then access cycle until pready
  task automatic cfg_access(input logic wr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_REQUIRED_RUN;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write the threshold and read it back
  task automatic set_required_run(input logic [31:0] value);
    cfg_access(1'b1, value);
    @(posedge clk);
    cfg_access(1'b0, 32'h0);
    @(posedge clk);
  endtask

  // drain: stop sending, wait for every result, then cover the pipeline
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // bursts of clean sequence, sparse single errors, and pure noise
  task automatic run_random(input int count);
    int left;
    int mode;
    int burst;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(99);
      burst = $urandom_range(1, 60);
      repeat (burst) begin
        if (left > 0) begin
          if (mode < 50)
            send_prbs(1'b0);
          else if (mode < 85)
            send_prbs($urandom_range(39) == 0);
          else
            send_sample(8'($urandom));
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold should come up at its reset value
    cfg_access(1'b0, 32'h0);
    @(posedge clk);

    // sender light, receiver heavy
    send_idle_pct = 15;
    recv_stall_pct = 79;

    // priming: byte extremes first, then random bytes; nothing is compared yet
    for (int i = 0; i < PRIME_COUNT; i++) begin
      if (i < 8)
        send_sample(corner_bytes[i]);
      else
        send_prbs(1'b0);
    end
    // first compared requests: clean, error, back-to-back errors, run restart
    send_prbs(1'b0);
    send_prbs(1'b1);
    send_prbs(1'b1);
    repeat (4) send_prbs(1'b0);
    send_prbs(1'b1);
    repeat (3) send_prbs(1'b0);
    drain_results();

    // threshold zero: enough always set
    set_required_run(32'h0000_0000);
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // threshold at maximum: enough never set; sender heavy, receiver light
    set_required_run(32'hFFFF_FFFF);
    send_idle_pct = 79;
    recv_stall_pct = 15;
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // threshold within reach of random runs; no idling from here on
    set_required_run(32'd150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
    drain_results();

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
